// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the port checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is low
`define SRM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("srm assertion failed");

// clocked assertion, also checked during reset
`define SRM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("srm assertion failed");

`endif

// ----- hw/rtl/srm_pkg.sv -----
// servo rule mixer package: sizes, request codes, table entry types
// no dependencies
`default_nettype none
package srm_pkg;
    localparam int RULE_DEPTH   = 16;
    localparam int SERVO_COUNT  = 8;
    localparam int SOURCE_COUNT = 16;
    localparam int RULE_AW      = $clog2(RULE_DEPTH);
    localparam int SERVO_AW     = $clog2(SERVO_COUNT);
    localparam int SOURCE_AW    = $clog2(SOURCE_COUNT);

    localparam logic [1:0] REQ_RULE   = 2'd0;
    localparam logic [1:0] REQ_SERVO  = 2'd1;
    localparam logic [1:0] REQ_SOURCE = 2'd2;
    localparam logic [1:0] REQ_MIX    = 2'd3;

    localparam logic [11:0] SERVO_MIN_RST = 12'd1000;
    localparam logic [11:0] SERVO_MAX_RST = 12'd2000;
    localparam logic [11:0] SERVO_MID_RST = 12'd1500;
    localparam logic signed [7:0] SERVO_RATE_RST = 8'sd100;

    localparam int DIV_W = 28;
    localparam int QUO_W = 23;

    typedef struct packed {
        logic [2:0]        target;
        logic [3:0]        source;
        logic signed [7:0] rate;
        logic [7:0]        speed;
        logic [11:0]       lo_pct;
        logic [11:0]       hi_pct;
        logic [15:0]       box;
    } t_rule;

    typedef struct packed {
        logic [11:0]       min;
        logic [11:0]       max;
        logic [11:0]       middle;
        logic signed [7:0] rate;
        logic [15:0]       reversed;
    } t_servo;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [DIV_W-1:0] mag;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [QUO_W-1:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

// ----- hw/rtl/srm_if.sv -----
// word channels of the servo rule mixer: request in, servo command out
// depends on nothing
`default_nettype none
interface srm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [3:0]         entry_index;
    logic [2:0]         target_servo;
    logic [3:0]         source_sel;
    logic signed [7:0]  weight;
    logic [7:0]         speed;
    logic [11:0]        low_value;
    logic [11:0]        high_value;
    logic [11:0]        middle_value;
    logic [15:0]        mask_value;
    logic signed [11:0] sample_value;
    modport source(output valid, req_type, entry_index, target_servo, source_sel, weight,
                   speed, low_value, high_value, middle_value, mask_value, sample_value,
                   input ready);
    modport sink(input valid, req_type, entry_index, target_servo, source_sel, weight,
                 speed, low_value, high_value, middle_value, mask_value, sample_value,
                 output ready);
endinterface

interface srm_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         servo_index;
    logic signed [15:0] servo_value;
    logic               last;
    modport source(output valid, servo_index, servo_value, last, input ready);
    modport sink(input valid, servo_index, servo_value, last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/servo_rule_mixer.sv -----
// servo rule mixer: write requests load the tables while idle; a mix request walks the
// rules and then the servos through one multiplier and one divider by one hundred
// an active rule runs three divisions (low bound, high bound, term), an inactive none;
// each servo runs one division and then waits for its word to be taken
// synchronous active-low reset; tables return to their defaults, rule count to zero
`default_nettype none
module servo_rule_mixer (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           psel,
    input  wire           penable,
    input  wire           pwrite,
    input  wire [1:0]     paddr,
    input  wire [31:0]    pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    srm_in_if.sink        i_in,
    srm_out_if.source     o_out
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RULE  = 3'd1;
    localparam logic [2:0] S_DLO   = 3'd2;
    localparam logic [2:0] S_DHI   = 3'd3;
    localparam logic [2:0] S_DTERM = 3'd4;
    localparam logic [2:0] S_SRV   = 3'd5;
    localparam logic [2:0] S_DSRV  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    srm_pkg::t_rule  r_rules [srm_pkg::RULE_DEPTH];
    srm_pkg::t_servo r_servos[srm_pkg::SERVO_COUNT];
    logic signed [11:0] r_src [srm_pkg::SOURCE_COUNT];
    logic signed [11:0] r_rout[srm_pkg::RULE_DEPTH];
    logic signed [15:0] r_sums[srm_pkg::SERVO_COUNT];

    logic [2:0]  r_state, n_state;
    logic [4:0]  r_rule_cnt;
    logic [4:0]  r_n;
    logic [5:0]  r_idx;
    logic [4:0]  r_srv;
    logic [15:0] r_mask;
    logic signed [11:0] r_cur;
    logic [15:0] r_span;
    logic signed [15:0] r_lo, r_hi;
    logic        r_out_valid;
    logic [2:0]  r_out_idx;
    logic signed [15:0] r_out_val;
    logic        r_out_last;

    srm_pkg::t_div_req div_req;
    srm_pkg::t_div_rsp div_rsp;

    srm_pkg::t_rule  rule;
    srm_pkg::t_servo tsrv;
    srm_pkg::t_servo osrv;
    logic        active;
    logic        tgt_ok;
    logic signed [11:0] src_val, cur_old, cur_new;
    logic signed [12:0] up, dn;
    logic [15:0] span;
    logic [11:0] mul_a;
    logic [15:0] mul_b;
    logic [15:0] sum_sel;
    logic signed [15:0] q16, term, term_s, lo_new, hi_new;
    logic signed [15:0] sum_cur;
    logic        cfg_wr;
    logic        last_rule;
    logic [4:0]  idx_inc;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = {27'd0, r_rule_cnt};

    assign rule = r_rules[r_idx[srm_pkg::RULE_AW-1:0]];
    assign tsrv = r_servos[rule.target[srm_pkg::SERVO_AW-1:0]];
    assign osrv = r_servos[r_srv[srm_pkg::SERVO_AW-1:0]];

    always_comb begin
        if (rule.box == 16'd0)
            active = 1'b1;
        else if (rule.box <= 16'd16)
            active = r_mask[4'(rule.box - 16'd1)];
        else
            active = 1'b0;
    end

    assign tgt_ok  = (32'(rule.target) < srm_pkg::SERVO_COUNT);
    assign src_val = (32'(rule.source) < srm_pkg::SOURCE_COUNT)
                     ? r_src[rule.source[srm_pkg::SOURCE_AW-1:0]] : 12'sd0;
    assign cur_old = r_rout[r_idx[srm_pkg::RULE_AW-1:0]];
    assign up = 13'(cur_old) + $signed({5'd0, rule.speed});
    assign dn = 13'(cur_old) - $signed({5'd0, rule.speed});

    always_comb begin
        if (rule.speed == 8'd0)
            cur_new = src_val;
        else if (cur_old < src_val)
            cur_new = (up > 13'(src_val)) ? src_val : up[11:0];
        else if (cur_old > src_val)
            cur_new = (dn < 13'(src_val)) ? src_val : dn[11:0];
        else
            cur_new = cur_old;
    end

    assign span    = 16'({4'd0, tsrv.max} - {4'd0, tsrv.min});
    assign q16     = div_rsp.quo[15:0];
    assign lo_new  = 16'(q16 - $signed({1'b0, r_span[15:1]}));
    assign hi_new  = lo_new;
    assign sum_cur = r_sums[rule.target[srm_pkg::SERVO_AW-1:0]];
    assign sum_sel = r_sums[r_srv[srm_pkg::SERVO_AW-1:0]];

    always_comb begin
        if (div_rsp.quo < srm_pkg::QUO_W'(r_lo))
            term = r_lo;
        else if (div_rsp.quo > srm_pkg::QUO_W'(r_hi))
            term = r_hi;
        else
            term = q16;
        term_s = tsrv.reversed[rule.source] ? 16'(-term) : term;
    end

    // operand select for the shared multiplier and divider start
    always_comb begin
        div_req.start = 1'b0;
        div_req.neg   = 1'b0;
        mul_a = rule.lo_pct;
        mul_b = span;
        unique case (r_state)
            S_RULE: div_req.start = active && tgt_ok;
            S_DLO: begin
                div_req.start = div_rsp.done;
                mul_a = rule.hi_pct;
                mul_b = r_span;
            end
            S_DHI: begin
                div_req.start = div_rsp.done;
                div_req.neg   = r_cur[11] ^ rule.rate[7];
                mul_a = r_cur[11] ? 12'(-r_cur) : r_cur;
                mul_b = {8'd0, rule.rate[7] ? 8'(-rule.rate) : rule.rate};
            end
            S_SRV: begin
                div_req.start = 1'b1;
                div_req.neg   = osrv.rate[7] ^ sum_sel[15];
                mul_a = {4'd0, osrv.rate[7] ? 8'(-osrv.rate) : osrv.rate};
                mul_b = sum_sel[15] ? 16'(-sum_sel) : sum_sel;
            end
            default: ;
        endcase
        div_req.mag = 28'(mul_a) * 28'(mul_b);
    end

    srm_div100 u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign idx_inc   = 5'(r_idx + 6'd1);
    assign last_rule = ({1'b0, idx_inc} >= {1'b0, r_n});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid && i_in.req_type == srm_pkg::REQ_MIX)
                    n_state = (r_rule_cnt == 5'd0) ? S_SRV : S_RULE;
            end
            S_RULE: begin
                if (active && tgt_ok)
                    n_state = S_DLO;
                else if (last_rule)
                    n_state = S_SRV;
            end
            S_DLO:   if (div_rsp.done) n_state = S_DHI;
            S_DHI:   if (div_rsp.done) n_state = S_DTERM;
            S_DTERM: if (div_rsp.done) n_state = last_rule ? S_SRV : S_RULE;
            S_SRV:   n_state = S_DSRV;
            S_DSRV:  if (div_rsp.done) n_state = S_OUT;
            S_OUT: begin
                if (o_out.ready)
                    n_state = (32'(r_srv) == srm_pkg::SERVO_COUNT - 1) ? S_IDLE : S_SRV;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rule_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_srv       <= '0;
            for (int k = 0; k < srm_pkg::RULE_DEPTH; k++) begin
                r_rules[k] <= '0;
                r_rout[k]  <= '0;
            end
            for (int k = 0; k < srm_pkg::SOURCE_COUNT; k++)
                r_src[k] <= '0;
            for (int k = 0; k < srm_pkg::SERVO_COUNT; k++) begin
                r_sums[k]   <= '0;
                r_servos[k] <= '{min: srm_pkg::SERVO_MIN_RST, max: srm_pkg::SERVO_MAX_RST,
                                 middle: srm_pkg::SERVO_MID_RST,
                                 rate: srm_pkg::SERVO_RATE_RST, reversed: 16'd0};
            end
        end else begin
            r_state <= n_state;
            if (cfg_wr)
                r_rule_cnt <= pwdata[4:0];
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        unique case (i_in.req_type)
                            srm_pkg::REQ_RULE: begin
                                if (32'(i_in.entry_index) < srm_pkg::RULE_DEPTH)
                                    r_rules[i_in.entry_index[srm_pkg::RULE_AW-1:0]] <=
                                        '{target: i_in.target_servo, source: i_in.source_sel,
                                          rate: i_in.weight, speed: i_in.speed,
                                          lo_pct: i_in.low_value, hi_pct: i_in.high_value,
                                          box: i_in.mask_value};
                            end
                            srm_pkg::REQ_SERVO: begin
                                if (32'(i_in.entry_index) < srm_pkg::SERVO_COUNT)
                                    r_servos[i_in.entry_index[srm_pkg::SERVO_AW-1:0]] <=
                                        '{min: i_in.low_value, max: i_in.high_value,
                                          middle: i_in.middle_value, rate: i_in.weight,
                                          reversed: i_in.mask_value};
                            end
                            srm_pkg::REQ_SOURCE: begin
                                if (32'(i_in.entry_index) < srm_pkg::SOURCE_COUNT)
                                    r_src[i_in.entry_index[srm_pkg::SOURCE_AW-1:0]] <=
                                        i_in.sample_value;
                            end
                            srm_pkg::REQ_MIX: begin
                                r_mask <= i_in.mask_value;
                                r_idx  <= '0;
                                r_srv  <= '0;
                                r_n    <= (32'(r_rule_cnt) > srm_pkg::RULE_DEPTH)
                                          ? 5'(srm_pkg::RULE_DEPTH) : r_rule_cnt;
                                for (int k = 0; k < srm_pkg::SERVO_COUNT; k++)
                                    r_sums[k] <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RULE: begin
                    if (!active) begin
                        r_rout[r_idx[srm_pkg::RULE_AW-1:0]] <= '0;
                    end else begin
                        r_rout[r_idx[srm_pkg::RULE_AW-1:0]] <= cur_new;
                    end
                    r_cur  <= cur_new;
                    r_span <= span;
                    if (!(active && tgt_ok))
                        r_idx <= {1'b0, idx_inc};
                end
                S_DLO: if (div_rsp.done) r_lo <= lo_new;
                S_DHI: if (div_rsp.done) r_hi <= hi_new;
                S_DTERM: begin
                    if (div_rsp.done) begin
                        r_sums[rule.target[srm_pkg::SERVO_AW-1:0]] <= 16'(sum_cur + term_s);
                        r_idx <= {1'b0, idx_inc};
                    end
                end
                S_DSRV: begin
                    if (div_rsp.done) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_srv[2:0];
                        r_out_val   <= 16'(q16 + $signed({4'd0, osrv.middle}));
                        r_out_last  <= (32'(r_srv) == srm_pkg::SERVO_COUNT - 1);
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        r_srv <= 5'(r_srv + 5'd1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.servo_index = r_out_idx;
    assign o_out.servo_value = r_out_val;
    assign o_out.last        = r_out_last;
endmodule
`default_nettype wire

// ----- hw/rtl/srm_div100.sv -----
// divider by one hundred through a reciprocal multiply, truncating; operand and quotient are registered
// depends on srm_pkg
`default_nettype none
module srm_div100 (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  srm_pkg::t_div_req i_req,
    output srm_pkg::t_div_rsp o_rsp
);
    // x / 100 == (x >> 2) / 25, reciprocal of 25 scaled by 2^31 is exact for 26-bit operands
    localparam int MAG_W    = srm_pkg::DIV_W - 2;
    localparam int RECIP_W  = 27;
    localparam int PROD_W   = MAG_W + RECIP_W;
    localparam int RECIP_SH = 31;
    localparam logic [RECIP_W-1:0] RECIP = 27'd85899346;

    logic                        r_busy;
    logic                        r_neg;
    logic [MAG_W-1:0]            r_mag;
    logic [srm_pkg::QUO_W-2:0]   r_quo;
    logic                        r_done;
    logic [PROD_W-1:0]           prod;
    logic [srm_pkg::QUO_W-1:0]   quo_mag;

    assign prod    = PROD_W'(r_mag) * PROD_W'(RECIP);
    assign quo_mag = {1'b0, r_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_neg  <= i_req.neg;
                r_mag  <= i_req.mag[srm_pkg::DIV_W-1:2];
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
                r_quo  <= prod[RECIP_SH +: srm_pkg::QUO_W-1];
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -$signed(quo_mag) : $signed(quo_mag);
endmodule
`default_nettype wire

// ----- hw/rtl/srm_checker.sv -----
// port checker for the servo rule mixer, bound to the top level
// depends on srm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module srm_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire       i_out_last,
    input wire [2:0] i_out_index
);
    localparam logic [2:0] LAST_SERVO = 3'(srm_pkg::SERVO_COUNT - 1);

    `SRM_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `SRM_ASSERT(a_no_overlap, i_clk, i_rst_n, !(i_in_ready && i_out_valid))
    `SRM_ASSERT(a_last_servo, i_clk, i_rst_n, i_out_valid && i_out_last |-> i_out_index == LAST_SERVO)
    `SRM_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_out_valid && i_in_ready)
endmodule

bind servo_rule_mixer srm_checker u_srm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_last (o_out.last),
    .i_out_index(o_out.servo_index)
);
`default_nettype wire

// ----- sim/srm_mix_checker.sv -----
`timescale 1ns / 100ps
// servo rule mixer checker: watches the request, command and register ports,
// predicts each servo command word and compares it; uses srm_pkg and srm_if
`default_nettype none
module srm_mix_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [1:0]  paddr,
    input  wire [31:0] pwdata,
    input  wire        pready,
    srm_in_if          req_mon,
    srm_out_if         cmd_mon,
    output int         o_errors,
    output int         o_pending
);
    import srm_pkg::*;

    typedef struct {
        logic [2:0]         servo;
        logic signed [15:0] value;
        logic               last;
    } t_cmd;

    t_rule  rules [RULE_DEPTH];
    t_servo servos [SERVO_COUNT];
    int     src_vals [SOURCE_COUNT];
    int     slew_vals [RULE_DEPTH];
    int     sums [SERVO_COUNT];
    logic [4:0] active_rules;
    t_cmd   cmd_q[$];

    assign o_pending = cmd_q.size();

    function automatic int wrap16(longint v);
        logic [15:0] t;
        t = v[15:0];
        return int'($signed(t));
    endfunction

    function automatic int clamp(int x, int lo, int hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        o_errors++;
    endtask

    task automatic clear_tables();
        for (int i = 0; i < RULE_DEPTH; i++) begin
            rules[i] = '0;
            slew_vals[i] = 0;
        end
        for (int i = 0; i < SOURCE_COUNT; i++) src_vals[i] = 0;
        for (int i = 0; i < SERVO_COUNT; i++) begin
            servos[i] = '{SERVO_MIN_RST, SERVO_MAX_RST, SERVO_MID_RST, SERVO_RATE_RST, 16'h0};
            sums[i] = 0;
        end
        active_rules = '0;
        cmd_q.delete();
    endtask

    task automatic predict_mix(logic [15:0] box_mask);
        int n, src, cur, spd, term, lo, hi, v;
        longint span;
        bit on;
        t_rule r;
        t_servo s;
        t_cmd c;
        for (int i = 0; i < SERVO_COUNT; i++) sums[i] = 0;
        n = active_rules < RULE_DEPTH ? active_rules : RULE_DEPTH;
        for (int i = 0; i < n; i++) begin
            r = rules[i];
            if (r.box == 0) on = 1;
            else if (r.box <= 16) on = box_mask[r.box - 1];
            else on = 0;
            if (!on) begin
                slew_vals[i] = 0;
                continue;
            end
            src = src_vals[r.source];
            cur = slew_vals[i];
            spd = int'(r.speed);
            if (spd == 0) cur = src;
            else if (cur < src) cur = clamp(cur + spd, cur, src);
            else if (cur > src) cur = clamp(cur - spd, src, cur);
            slew_vals[i] = cur;
            s = servos[r.target];
            span = longint'((int'(s.max) - int'(s.min)) & 32'hFFFF);
            lo = wrap16(longint'(r.lo_pct) * span / 100 - span / 2);
            hi = wrap16(longint'(r.hi_pct) * span / 100 - span / 2);
            term = clamp(cur * int'($signed(r.rate)) / 100, lo, hi);
            if (s.reversed[r.source]) term = -term;
            sums[r.target] = wrap16(longint'(sums[r.target]) + term);
        end
        for (int i = 0; i < SERVO_COUNT; i++) begin
            v = wrap16(longint'($signed(servos[i].rate)) * sums[i] / 100);
            v = wrap16(longint'(v) + servos[i].middle);
            c.servo = i[2:0];
            c.value = v[15:0];
            c.last = (i == SERVO_COUNT - 1);
            cmd_q.push_back(c);
        end
    endtask

    initial begin
        o_errors = 0;
        clear_tables();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_tables();
        end else begin
            if (psel && penable && pwrite && pready && paddr == 2'd0)
                active_rules = pwdata[4:0];
            if (req_mon.valid && req_mon.ready) begin
                case (req_mon.req_type)
                    REQ_RULE: begin
                        rules[req_mon.entry_index] = '{req_mon.target_servo,
                            req_mon.source_sel, req_mon.weight, req_mon.speed,
                            req_mon.low_value, req_mon.high_value, req_mon.mask_value};
                    end
                    REQ_SERVO: begin
                        if (req_mon.entry_index < SERVO_COUNT)
                            servos[req_mon.entry_index] = '{req_mon.low_value,
                                req_mon.high_value, req_mon.middle_value,
                                req_mon.weight, req_mon.mask_value};
                    end
                    REQ_SOURCE: begin
                        src_vals[req_mon.entry_index] = int'(req_mon.sample_value);
                    end
                    default: predict_mix(req_mon.mask_value);
                endcase
            end
            if (cmd_mon.valid && cmd_mon.ready) begin
                if (cmd_q.size() == 0) begin
                    report("unexpected word", int'(cmd_mon.servo_value), 0);
                end else begin
                    t_cmd c;
                    c = cmd_q.pop_front();
                    if (cmd_mon.servo_index != c.servo)
                        report("servo_index", cmd_mon.servo_index, c.servo);
                    if (cmd_mon.servo_value != c.value)
                        report("servo_value", cmd_mon.servo_value, c.value);
                    if (cmd_mon.last != c.last)
                        report("last", cmd_mon.last, c.last);
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// servo rule mixer testbench top: clock, reset, register writes, request words
// and stall patterns; uses srm_pkg, srm_if, servo_rule_mixer and srm_mix_checker
`default_nettype none
module tb_top;
    import srm_pkg::*;

    typedef struct {
        logic [1:0]         req;
        logic [3:0]         idx;
        logic [2:0]         tgt;
        logic [3:0]         src;
        logic signed [7:0]  wt;
        logic [7:0]         spd;
        logic [11:0]        lo;
        logic [11:0]        hi;
        logic [11:0]        mid;
        logic [15:0]        mask;
        logic signed [11:0] smp;
    } t_req;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int errors, pending;
    int tx_idle = 6, rx_idle = 54;

    srm_in_if  req_ch();
    srm_out_if cmd_ch();

    servo_rule_mixer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .i_in(req_ch.sink), .o_out(cmd_ch.source)
    );

    srm_mix_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .req_mon(req_ch), .cmd_mon(cmd_ch), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        req_ch.valid = 0;
        req_ch.req_type = REQ_RULE;
        req_ch.entry_index = '0;
        req_ch.target_servo = '0;
        req_ch.source_sel = '0;
        req_ch.weight = '0;
        req_ch.speed = '0;
        req_ch.low_value = '0;
        req_ch.high_value = '0;
        req_ch.middle_value = '0;
        req_ch.mask_value = '0;
        req_ch.sample_value = '0;
        cmd_ch.ready = 0;
    end

    always @(posedge i_clk)
        cmd_ch.ready <= ($urandom_range(99) >= rx_idle);

    task automatic reg_write(logic [4:0] count);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 2'd0;
        pwdata <= {27'd0, count};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic send(t_req w);
        while ($urandom_range(99) < tx_idle) begin
            req_ch.valid <= 0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.req_type <= w.req;
        req_ch.entry_index <= w.idx;
        req_ch.target_servo <= w.tgt;
        req_ch.source_sel <= w.src;
        req_ch.weight <= w.wt;
        req_ch.speed <= w.spd;
        req_ch.low_value <= w.lo;
        req_ch.high_value <= w.hi;
        req_ch.middle_value <= w.mid;
        req_ch.mask_value <= w.mask;
        req_ch.sample_value <= w.smp;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    function automatic t_req mk(logic [1:0] req, int idx, int tgt, int src, int wt,
                                int spd, int lo, int hi, int mid, int mask, int smp);
        t_req w;
        w = '{req, idx[3:0], tgt[2:0], src[3:0], wt[7:0], spd[7:0], lo[11:0],
              hi[11:0], mid[11:0], mask[15:0], smp[11:0]};
        return w;
    endfunction

    function automatic t_req rand_req();
        t_req w;
        int pick;
        w = mk(2'($urandom_range(3)), $urandom_range(15), $urandom_range(7),
               $urandom_range(15), int'($urandom_range(250)) - 125, $urandom_range(255),
               $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
               $urandom_range(65535), int'($urandom_range(4095)) - 2048);
        pick = $urandom_range(99);
        if (pick < 30) w.req = REQ_RULE;
        else if (pick < 42) w.req = REQ_SERVO;
        else if (pick < 72) w.req = REQ_SOURCE;
        else w.req = REQ_MIX;
        if (w.req == REQ_RULE) begin
            if ($urandom_range(9) < 8) begin
                w.lo = 12'($urandom_range(60));
                w.hi = 12'($urandom_range(40, 110));
                w.mask = 16'($urandom_range(16));
                if ($urandom_range(3) == 0) w.spd = 8'($urandom_range(40));
            end
        end else if (w.req == REQ_SERVO && $urandom_range(9) < 8) begin
            w.lo = 12'($urandom_range(800, 1200));
            w.hi = 12'($urandom_range(1800, 2200));
            w.mid = 12'($urandom_range(1300, 1700));
        end
        return w;
    endfunction

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // empty rule set, then the table extremes
        send(mk(REQ_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0));
        send(mk(REQ_SERVO, 0, 0, 0, 125, 0, 0, 4095, 4095, 16'h0000, 0));
        send(mk(REQ_SERVO, 1, 0, 0, -125, 0, 4095, 0, 0, 16'hFFFF, 0));
        send(mk(REQ_SERVO, 9, 0, 0, 7, 0, 1, 2, 3, 16'h1234, 0));
        send(mk(REQ_SOURCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, -2048));
        send(mk(REQ_SOURCE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 2047));
        send(mk(REQ_SOURCE, 15, 0, 0, 0, 0, 0, 0, 0, 0, -1));
        send(mk(REQ_RULE, 0, 0, 0, 125, 0, 0, 100, 0, 0, 0));
        send(mk(REQ_RULE, 1, 1, 1, -125, 255, 0, 4095, 0, 16, 0));
        send(mk(REQ_RULE, 2, 0, 1, 100, 100, 4095, 0, 0, 1, 0));
        send(mk(REQ_RULE, 3, 2, 15, 50, 0, 0, 100, 0, 17, 0));
        send(mk(REQ_RULE, 4, 1, 0, 125, 3, 80, 20, 0, 16'hFFFF, 0));
        send(mk(REQ_RULE, 5, 7, 1, 125, 0, 0, 4095, 0, 0, 0));
        send(mk(REQ_RULE, 6, 7, 1, 125, 0, 0, 4095, 0, 0, 0));
        send(mk(REQ_RULE, 15, 0, 0, 1, 1, 0, 100, 0, 0, 0));
        drain();
        reg_write(5'd16);
        send(mk(REQ_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0));
        send(mk(REQ_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 16'h8001, 0));
        send(mk(REQ_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 0));
        send(mk(REQ_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 16'h8000, 0));
        drain();
        reg_write(5'd31);
        send(mk(REQ_MIX, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0));
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 6 : (ph == 1) ? 54 : 0;
            rx_idle = (ph == 0) ? 54 : (ph == 1) ? 6 : 0;
            reg_write(ph == 0 ? 5'd16 : ph == 1 ? 5'($urandom_range(1, 15)) : 5'd0);
            for (int k = 0; k < 157; k++) begin
                if (ph == 2 && k == 20) begin
                    drain();
                    reg_write(5'd16);
                end
                if (k == 80) drain();
                send(rand_req());
            end
            drain();
        end
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: errors");
        $finish;
    end
endmodule
`default_nettype wire
